FILE: rtl/utf8_stream_validator_core_assert.svh
// Assertion macros used by the checker file of the UTF-8 validator.
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define U8V_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define U8V_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/utf8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Byte classes, sequence classes, the queue entry type and code point limits.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CP_W        = 21;

    localparam logic [CP_W-1:0] CP_MIN_TWO   = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h0DFFF;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } t_kind;

    // Length class of the open sequence.
    typedef enum logic [1:0] {
        CLASS_NONE,
        CLASS_TWO,
        CLASS_THREE,
        CLASS_FOUR
    } t_seq_class;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] payload;
        logic       last;
    } t_byte_info;

endpackage

FILE: rtl/utf8v_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator byte classifier
// Sorts an incoming byte into its class and extracts its payload bits.
// ----------------------------------------------------------------------------
module utf8v_front (
    input  logic                  [7:0] i_data_byte,
    input  logic                        i_end_of_string,
    output utf8v_pkg::t_byte_info       o_info
);

    always_comb begin
        o_info.last    = i_end_of_string;
        o_info.payload = i_data_byte[5:0];
        if (i_data_byte[7] == 1'b0) begin
            o_info.kind = utf8v_pkg::KIND_ASCII;
        end else if (i_data_byte[7:6] == 2'b10) begin
            o_info.kind = utf8v_pkg::KIND_CONT;
        end else if (i_data_byte[7:5] == 3'b110) begin
            o_info.kind    = utf8v_pkg::KIND_LEAD2;
            o_info.payload = {1'b0, i_data_byte[4:0]};
        end else if (i_data_byte[7:4] == 4'b1110) begin
            o_info.kind    = utf8v_pkg::KIND_LEAD3;
            o_info.payload = {2'b00, i_data_byte[3:0]};
        end else if (i_data_byte[7:3] == 5'b11110) begin
            o_info.kind    = utf8v_pkg::KIND_LEAD4;
            o_info.payload = {3'b000, i_data_byte[2:0]};
        end else begin
            o_info.kind = utf8v_pkg::KIND_BAD;
        end
    end

endmodule

FILE: rtl/utf8v_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator queue
// Short register queue of classified beats between classifier and checker.
// ----------------------------------------------------------------------------
module utf8v_queue #(
    parameter int DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  utf8v_pkg::t_byte_info i_wdata,
    output logic                  o_full,
    input  logic                  i_pop,
    output utf8v_pkg::t_byte_info o_rdata,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    utf8v_pkg::t_byte_info r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == COUNT_MAX);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/utf8v_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator sequence checker
// Tracks the open sequence, flags errors and registers the verdict per string.
// ----------------------------------------------------------------------------
module utf8v_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  utf8v_pkg::t_byte_info i_info,
    input  logic                  i_info_valid,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output logic                  o_string_valid,
    input  logic                  i_out_ready
);

    localparam int CW = utf8v_pkg::CP_W;

    logic [1:0]            r_pending;
    logic [CW-1:0]         r_cp;
    utf8v_pkg::t_seq_class r_class;
    logic                  r_err;
    logic                  r_out_valid;
    logic                  r_out_bit;

    logic [1:0]            n_pending;
    logic [CW-1:0]         n_cp;
    utf8v_pkg::t_seq_class n_class;
    logic                  n_err;

    logic [CW-1:0] cp_shift;
    logic [CW-1:0] cp_min;

    // A final beat needs the result register free; other beats always move.
    assign o_pop          = i_info_valid && (!i_info.last || !r_out_valid || i_out_ready);
    assign o_out_valid    = r_out_valid;
    assign o_string_valid = r_out_bit;
    assign cp_shift       = {r_cp[CW-7:0], i_info.payload};

    always_comb begin
        unique case (r_class)
            utf8v_pkg::CLASS_TWO:   cp_min = utf8v_pkg::CP_MIN_TWO;
            utf8v_pkg::CLASS_THREE: cp_min = utf8v_pkg::CP_MIN_THREE;
            default:                cp_min = utf8v_pkg::CP_MIN_FOUR;
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_cp      = r_cp;
        n_class   = r_class;
        n_err     = r_err;
        if (!r_err) begin
            if (r_pending == 2'd0) begin
                unique case (i_info.kind)
                    utf8v_pkg::KIND_ASCII: begin
                    end
                    utf8v_pkg::KIND_LEAD2: begin
                        n_pending = 2'd1;
                        n_cp      = {{(CW-6){1'b0}}, i_info.payload};
                        n_class   = utf8v_pkg::CLASS_TWO;
                    end
                    utf8v_pkg::KIND_LEAD3: begin
                        n_pending = 2'd2;
                        n_cp      = {{(CW-6){1'b0}}, i_info.payload};
                        n_class   = utf8v_pkg::CLASS_THREE;
                    end
                    utf8v_pkg::KIND_LEAD4: begin
                        n_pending = 2'd3;
                        n_cp      = {{(CW-6){1'b0}}, i_info.payload};
                        n_class   = utf8v_pkg::CLASS_FOUR;
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end else if (i_info.kind != utf8v_pkg::KIND_CONT) begin
                n_err     = 1'b1;
                n_pending = 2'd0;
            end else begin
                n_cp      = cp_shift;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    // Sequence complete: reject overlong forms, surrogates and
                    // values past the top of the code space.
                    if (cp_shift < cp_min || cp_shift > utf8v_pkg::CP_MAX ||
                        (cp_shift >= utf8v_pkg::SURR_LO &&
                         cp_shift <= utf8v_pkg::SURR_HI)) begin
                        n_err = 1'b1;
                    end
                    n_cp    = '0;
                    n_class = utf8v_pkg::CLASS_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 2'd0;
            r_cp        <= '0;
            r_class     <= utf8v_pkg::CLASS_NONE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_bit   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_info.last) begin
                    r_pending   <= 2'd0;
                    r_cp        <= '0;
                    r_class     <= utf8v_pkg::CLASS_NONE;
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_out_bit   <= !n_err && (n_pending == 2'd0);
                end else begin
                    r_pending <= n_pending;
                    r_cp      <= n_cp;
                    r_class   <= n_class;
                    r_err     <= n_err;
                end
            end
        end
    end

endmodule

FILE: rtl/utf8_stream_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a byte stream against the UTF-8 rules and reports one verdict per
// string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one byte per beat on
//   i_data_byte, with i_end_of_string high on the final byte of a string.
//   Output channel: o_out_valid / i_out_ready carry one beat per string on
//   o_string_valid, high when the whole string was well-formed.
//   Bytes that are not the last of a string produce no output beat.
//   Path: a final byte goes through the queue to the checker, which registers
//   its verdict in the result register once that register is free.
//   Throughput: one byte per cycle while o_in_ready is high, set by the
//   update of the sequence checker; the classifier and checker are split by a
//   two-entry queue.
//   Reset clears the queue, the sequence state and the result register; the
//   block takes bytes in the first cycle after reset.
//   When the receiver stalls with a result pending, non-final bytes keep
//   flowing; the next final byte waits in the queue, and the queue fills
//   and drops o_in_ready after one further byte.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core #(
    parameter int QUEUE_DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_string_valid
);

    utf8v_pkg::t_byte_info front_info;
    utf8v_pkg::t_byte_info queue_info;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  back_pop;

    assign o_in_ready = !queue_full;

    utf8v_front u_front (
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_info          (front_info)
    );

    utf8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_wdata (front_info),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_rdata (queue_info),
        .o_empty (queue_empty)
    );

    utf8v_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_info         (queue_info),
        .i_info_valid   (!queue_empty),
        .o_pop          (back_pop),
        .o_out_valid    (o_out_valid),
        .o_string_valid (o_string_valid),
        .i_out_ready    (i_out_ready)
    );

endmodule

FILE: rtl/utf8v_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator port checker
// Watches the top-level ports: each result follows a final byte, a stalled result holds, reset state.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_core_assert.svh"

module utf8v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_end_of_string,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_string_valid
);

    // Final bytes accepted whose verdict has not been taken yet.
    logic [3:0] r_open;
    logic       last_in;
    logic       res_out;

    assign last_in = i_in_valid && o_in_ready && i_end_of_string;
    assign res_out = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (last_in && !res_out) begin
            r_open <= r_open + 4'd1;
        end else if (res_out && !last_in) begin
            r_open <= r_open - 4'd1;
        end
    end

    `U8V_ASSERT(a_result_needs_final, i_clk, i_rst_n, o_out_valid |-> (r_open != 4'd0), "result beat without a pending final byte")
    `U8V_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_string_valid), "stalled result changed")
    `U8V_ASSERT_ALWAYS(a_reset_out_idle, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid right after reset")
    `U8V_ASSERT_ALWAYS(a_reset_in_ready, i_clk, $past(!i_rst_n) |-> o_in_ready, "input not ready right after reset")

endmodule

bind utf8_stream_validator_core utf8v_checker u_utf8v_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator testbench
// Sends strings one byte per beat, predicts the verdict for each string with a
// decoder of its own, and checks every verdict beat against it in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_GAP        = 6;
    localparam int CP_W           = utf8v_pkg::CP_W;

    typedef enum int {
        CH_WELL_FORMED,
        CH_OVERLONG,
        CH_SURROGATE,
        CH_ABOVE_MAX,
        CH_RAW_BYTE,
        CH_BAD_CONT,
        CH_TRUNCATED
    } t_char_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_end_of_string;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_string_valid;

    // Decoder state that tracks the block.
    logic [1:0]            pend_cnt;
    logic [CP_W-1:0]       cp_acc;
    utf8v_pkg::t_seq_class seq_cls;
    logic                  err_flag;

    logic            verdict_q[$];
    logic [7:0]      str_buf[$];
    int              mismatch_count;
    int              idle_cycles;
    bit              tx_idle_en;
    bit              rx_idle_en;
    bit              rx_hold_req;

    utf8_stream_validator_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_string_valid  (o_string_valid)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_verdict(input logic v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        str_buf.insert(str_buf.size(), b);
    endfunction

    function automatic void clear_decoder();
        pend_cnt = 2'd0;
        cp_acc   = '0;
        seq_cls  = utf8v_pkg::CLASS_NONE;
        err_flag = 1'b0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic [CP_W-1:0] cp_min;
        if (!err_flag) begin
            if (pend_cnt == 2'd0) begin
                if (b[7]) begin
                    if (b[7:5] == 3'b110) begin
                        pend_cnt = 2'd1;
                        cp_acc   = {16'd0, b[4:0]};
                        seq_cls  = utf8v_pkg::CLASS_TWO;
                    end else if (b[7:4] == 4'b1110) begin
                        pend_cnt = 2'd2;
                        cp_acc   = {17'd0, b[3:0]};
                        seq_cls  = utf8v_pkg::CLASS_THREE;
                    end else if (b[7:3] == 5'b11110) begin
                        pend_cnt = 2'd3;
                        cp_acc   = {18'd0, b[2:0]};
                        seq_cls  = utf8v_pkg::CLASS_FOUR;
                    end else begin
                        err_flag = 1'b1;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                err_flag = 1'b1;
                pend_cnt = 2'd0;
            end else begin
                cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
                pend_cnt = pend_cnt - 2'd1;
                if (pend_cnt == 2'd0) begin
                    cp_min = (seq_cls == utf8v_pkg::CLASS_TWO)   ? utf8v_pkg::CP_MIN_TWO :
                             (seq_cls == utf8v_pkg::CLASS_THREE) ? utf8v_pkg::CP_MIN_THREE :
                                                                   utf8v_pkg::CP_MIN_FOUR;
                    if (cp_acc < cp_min || cp_acc > utf8v_pkg::CP_MAX ||
                        (cp_acc >= utf8v_pkg::SURR_LO && cp_acc <= utf8v_pkg::SURR_HI)) begin
                        err_flag = 1'b1;
                    end
                    cp_acc  = '0;
                    seq_cls = utf8v_pkg::CLASS_NONE;
                end
            end
        end
        if (last) begin
            add_verdict(!err_flag && pend_cnt == 2'd0);
            clear_decoder();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= last;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(b, last);
    endtask

    // Up to four bytes, first byte in the top lane.
    task automatic send_packed(input logic [31:0] seq, input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(seq[31-8*k -: 8], k == len - 1);
        end
    endtask

    task automatic send_str_buf();
        for (int k = 0; k < str_buf.size(); k++) begin
            send_byte(str_buf[k], k == str_buf.size() - 1);
        end
    endtask

    task automatic wait_all_verdicts();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    function automatic void encode_cp(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Legal code point for an n-byte form, often at the edge of its range.
    function automatic logic [CP_W-1:0] pick_code_point(input int n);
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        logic [CP_W-1:0] cp;
        case (n)
            1: begin
                lo = '0;
                hi = utf8v_pkg::CP_MIN_TWO - 21'd1;
            end
            2: begin
                lo = utf8v_pkg::CP_MIN_TWO;
                hi = utf8v_pkg::CP_MIN_THREE - 21'd1;
            end
            3: begin
                lo = utf8v_pkg::CP_MIN_THREE;
                hi = utf8v_pkg::CP_MIN_FOUR - 21'd1;
            end
            default: begin
                lo = utf8v_pkg::CP_MIN_FOUR;
                hi = utf8v_pkg::CP_MAX;
            end
        endcase
        case ($urandom_range(0, 7))
            0: cp = lo;
            1: cp = hi;
            2: cp = (n == 3) ? utf8v_pkg::SURR_LO - 21'd1 : lo + 21'd1;
            3: cp = (n == 3) ? utf8v_pkg::SURR_HI + 21'd1 : hi - 21'd1;
            default: cp = CP_W'($urandom_range(hi, lo));
        endcase
        // Surrogates are shifted up into the private use area.
        if (cp >= utf8v_pkg::SURR_LO && cp <= utf8v_pkg::SURR_HI) begin
            cp = cp + 21'h800;
        end
        return cp;
    endfunction

    function automatic void append_char(input bit clean);
        t_char_kind      kind;
        int              r;
        int              n;
        int              k;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] lim;
        r    = clean ? 0 : $urandom_range(0, 99);
        kind = (r < 50) ? CH_WELL_FORMED :
               (r < 60) ? CH_OVERLONG :
               (r < 68) ? CH_SURROGATE :
               (r < 75) ? CH_ABOVE_MAX :
               (r < 85) ? CH_RAW_BYTE :
               (r < 93) ? CH_BAD_CONT : CH_TRUNCATED;
        n = $urandom_range(2, 4);
        case (kind)
            CH_WELL_FORMED: begin
                n = $urandom_range(1, 4);
                encode_cp(pick_code_point(n), n);
            end
            CH_OVERLONG: begin
                lim = (n == 2) ? utf8v_pkg::CP_MIN_TWO :
                      (n == 3) ? utf8v_pkg::CP_MIN_THREE : utf8v_pkg::CP_MIN_FOUR;
                lim = lim - 21'd1;
                cp  = ($urandom_range(0, 2) == 0) ? lim : CP_W'($urandom_range(lim, 0));
                encode_cp(cp, n);
            end
            CH_SURROGATE: begin
                case ($urandom_range(0, 3))
                    0:       cp = utf8v_pkg::SURR_LO;
                    1:       cp = utf8v_pkg::SURR_HI;
                    default: cp = CP_W'($urandom_range(utf8v_pkg::SURR_HI,
                                                       utf8v_pkg::SURR_LO));
                endcase
                encode_cp(cp, 3);
            end
            CH_ABOVE_MAX: begin
                cp = ($urandom_range(0, 2) == 0) ? utf8v_pkg::CP_MAX + 21'd1 :
                     CP_W'($urandom_range(21'h1FFFFF, utf8v_pkg::CP_MAX + 21'd1));
                encode_cp(cp, 4);
            end
            CH_RAW_BYTE: begin
                add_byte(8'($urandom_range(0, 255)));
            end
            CH_BAD_CONT: begin
                encode_cp(pick_code_point(n), n);
                k = $urandom_range(1, n - 1);
                str_buf[str_buf.size() - k] = 8'($urandom_range(0, 255));
            end
            default: begin
                encode_cp(pick_code_point(n), n);
                repeat ($urandom_range(1, n - 1)) void'(str_buf.pop_back());
            end
        endcase
    endfunction

    // Most strings are made of well-formed characters only.
    function automatic void build_random_string();
        bit clean;
        str_buf.delete();
        clean = $urandom_range(0, 99) < 60;
        repeat ($urandom_range(1, 8)) append_char(clean);
    endfunction

    task automatic send_random_strings(input int target);
        int sent;
        sent = 0;
        while (sent < target) begin
            build_random_string();
            send_str_buf();
            sent += str_buf.size();
        end
    endtask

    task automatic test_well_formed_edges();
        send_packed(32'h007F_0000, 2);
        send_packed(32'hC280_0000, 2);
        send_packed(32'hEFBF_BF00, 3);
    endtask

    task automatic test_range_violations();
        send_packed(32'hC1BF_0000, 2);
        send_packed(32'hEDA0_8000, 3);
        send_packed(32'hF490_8080, 4);
    endtask

    task automatic test_malformed_bytes();
        // Cut short by the end, a broken continuation, a stray continuation
        // byte, and bytes that follow an invalid byte in the same string.
        send_packed(32'hF090_0000, 2);
        send_packed(32'hC241_0000, 2);
        send_packed(32'h8000_0000, 1);
        send_packed(32'hFFC2_8000, 3);
    endtask

    task automatic test_random_strings();
        send_random_strings(1200);
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_strings(300);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // The receiver stalls for a long stretch while bytes keep coming, so the
    // queue fills and the input side has to back off.
    task automatic test_receiver_hold();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        send_random_strings(300);
        tx_idle_en  = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (10) begin
            build_random_string();
            send_str_buf();
            wait_all_verdicts();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_data_byte     <= 8'd0;
        i_end_of_string <= 1'b0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_req    = 1'b0;
        mismatch_count = 0;
        clear_decoder();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_well_formed_edges();
        test_range_violations();
        test_malformed_bytes();
        wait_all_verdicts();
        test_random_strings();
        test_back_to_back();
        wait_all_verdicts();
        test_receiver_hold();
        test_sender_pause();

        wait_all_verdicts();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: one stall per verdict beat, then compare with the oldest
    // prediction.
    initial begin
        int   stall;
        logic exp_valid;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall       = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (verdict_q.size() == 0) begin
                $display("%0t: string_valid: expected no beat, actual %0b",
                         $time, o_string_valid);
                mismatch_count++;
            end else begin
                exp_valid = verdict_q.pop_front();
                if (o_string_valid !== exp_valid) begin
                    $display("%0t: string_valid: expected %0b, actual %0b",
                             $time, exp_valid, o_string_valid);
                    mismatch_count++;
                end
            end
        end
    end

    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no beat for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/utf8v_pkg.sv
rtl/utf8v_front.sv
rtl/utf8v_queue.sv
rtl/utf8v_back.sv
rtl/utf8_stream_validator_core.sv
rtl/utf8v_checker.sv
verif/tb_top.sv
